@@ hdl/wrq_pkg.sv @@
// Shared constants, action codes and interface types of the weighted ring queue.
package wrq_pkg;

   localparam int MAX_SLOTS = 64;
   localparam int ID_SPACE  = 64;

   localparam int ID_W    = 6;
   localparam int WT_W    = 32;
   localparam int CAP_W   = 7;
   localparam int ACT_W   = 3;
   localparam int SLOT_AW = $clog2(MAX_SLOTS);
   localparam int CNT_W   = SLOT_AW + 1;
   localparam int ID_AW   = $clog2(ID_SPACE);

   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;
   localparam int CSR_IDXW = 1;

   localparam logic [CSR_IDXW-1:0] REG_QUEUE_CAPACITY = 1'b0;
   localparam logic [CAP_W-1:0]    CAP_RESET          = CAP_W'(MAX_SLOTS);

   typedef enum logic [ACT_W-1:0] {
      ACT_ENQ   = 3'd0,
      ACT_DEQ   = 3'd1,
      ACT_SORT  = 3'd2,
      ACT_HAS   = 3'd3,
      ACT_CLEAR = 3'd4,
      ACT_SETW  = 3'd5
   } action_type;

   typedef struct packed {
      logic            en;
      logic [ID_W-1:0] id;
      logic [WT_W-1:0] data;
   } wt_wr_type;

endpackage

@@ hdl/wrq_weight_table.sv @@
// Weight table: one write port, one registered read port, unwritten words read as zero.
module wrq_weight_table
   import wrq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  wt_wr_type       wr,
   input  logic [ID_W-1:0] rd_id,
   output logic [WT_W-1:0] rd_data
);

   logic [WT_W-1:0] mem [ID_SPACE];
   logic [ID_SPACE-1:0] valid_ff;
   logic [WT_W-1:0] rd_data_ff;
   logic            rd_valid_ff;
   logic            wr_in_space;
   logic            rd_in_space;

   assign wr_in_space = 32'(wr.id) < ID_SPACE;
   assign rd_in_space = 32'(rd_id) < ID_SPACE;

   always_ff @(posedge clock) begin
      if (wr.en && wr_in_space) begin
         mem[ID_AW'(wr.id)] <= wr.data;
      end
      rd_data_ff <= mem[ID_AW'(rd_id)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en && wr_in_space) begin
            valid_ff[ID_AW'(wr.id)] <= 1'b1;
         end
         // identifiers outside the table weigh zero
         rd_valid_ff <= valid_ff[ID_AW'(rd_id)] && rd_in_space;
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ hdl/weighted_ring_queue.sv @@
// Top level of the weighted ring queue: slot memory, sequencer and ports.
//
//   channel  direction  handshake                     payload
//   req      in         req_valid / req_ready         action, entry_id, weight_value
//   rsp      out        rsp_valid / rsp_ready         head_entry .. is_full_flag
//   csr      in         APB psel/penable/pwrite       queue_capacity at byte 0
//
// One transaction at a time; req_ready is high only while the sequencer is idle.
// Enqueue, clear, set weight and unused codes go straight to ST_POST; dequeue passes
// through ST_DEQ unless empty, membership alternates ST_HAS and ST_HAS_CMP per slot
// scanned, and sort runs bubble passes in which each compare reads the slot memory
// and then the weight table through their single registered ports.
// Reset clears control state and the weight table valid bits at once; no sweep.
// A finished result waits in the rsp register; the sequencer stalls in ST_POST while an earlier result is untaken.
module weighted_ring_queue
   import wrq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ACT_W-1:0]    req_action,
   input  logic [ID_W-1:0]     req_entry_id,
   input  logic signed [WT_W-1:0] req_weight_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [ID_W-1:0]     rsp_head_entry,
   output logic                rsp_no_entity,
   output logic                rsp_found,
   output logic                rsp_rejected_full,
   output logic [CAP_W-1:0]    rsp_occupancy,
   output logic                rsp_is_empty_flag,
   output logic                rsp_is_full_flag,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEQ,
      ST_HAS,
      ST_HAS_CMP,
      ST_PASS,
      ST_CARRY_W,
      ST_CARRY_LD,
      ST_NEXT_W,
      ST_CMP,
      ST_LAST,
      ST_POST
   } state_type;

   function automatic logic [SLOT_AW-1:0] wrap_inc(input logic [SLOT_AW-1:0] idx,
                                                   input logic [CNT_W-1:0]   lim);
      logic [CNT_W-1:0] nxt;
      nxt = CNT_W'(idx) + CNT_W'(1);
      return (nxt >= lim) ? '0 : nxt[SLOT_AW-1:0];
   endfunction

   // slot memory
   logic [ID_W-1:0]    slot_mem [MAX_SLOTS];
   logic [ID_W-1:0]    slot_rd_ff;
   logic [SLOT_AW-1:0] slot_raddr;
   logic               slot_we;
   logic [SLOT_AW-1:0] slot_waddr;
   logic [ID_W-1:0]    slot_wdata;

   // weight table
   wt_wr_type          wt_wr;
   logic [WT_W-1:0]    wt_rd;

   // sequencer registers
   state_type          state_ff, state_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [SLOT_AW-1:0] head_ff, head_in;
   logic [SLOT_AW-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [SLOT_AW-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0]   step_ff, step_in;
   logic [CNT_W-1:0]   pass_ff, pass_in;
   logic [ID_W-1:0]    key_ff, key_in;
   logic [ID_W-1:0]    carry_ff, carry_in;
   logic [WT_W-1:0]    carry_w_ff, carry_w_in;
   logic [ID_W-1:0]    next_ff, next_in;
   logic [ID_W-1:0]    res_head_ff, res_head_in;
   logic               res_none_ff, res_none_in;
   logic               res_found_ff, res_found_in;
   logic               res_rej_ff, res_rej_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]    rsp_head_ff, rsp_head_in;
   logic               rsp_none_ff, rsp_none_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               rsp_rej_ff, rsp_rej_in;
   logic [CAP_W-1:0]   rsp_occ_ff, rsp_occ_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_full_ff, rsp_full_in;

   logic [CNT_W-1:0]   cap_eff;
   logic               csr_wr;
   logic [CSR_IDXW-1:0] csr_idx;
   logic               req_fire;
   logic               swap;
   logic [SLOT_AW-1:0] nptr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_AW-1 -: CSR_IDXW];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_idx == REG_QUEUE_CAPACITY) ? CSR_DW'(cap_ff) : '0;

   // clamp capacity into 1..MAX_SLOTS
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(cap_ff) > MAX_SLOTS) begin
         cap_eff = CNT_W'(MAX_SLOTS);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign nptr      = wrap_inc(ptr_ff, cap_eff);
   // sort compare: stable sort swaps only when the carried weight is strictly smaller
   assign swap      = $signed(carry_w_ff) < $signed(wt_rd);

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rd_ff <= slot_mem[slot_raddr];
   end

   wrq_weight_table u_weights (
      .clock   (clock),
      .reset   (reset),
      .wr      (wt_wr),
      .rd_id   (slot_rd_ff),
      .rd_data (wt_rd)
   );

   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      step_in       = step_ff;
      pass_in       = pass_ff;
      key_in        = key_ff;
      carry_in      = carry_ff;
      carry_w_in    = carry_w_ff;
      next_in       = next_ff;
      res_head_in   = res_head_ff;
      res_none_in   = res_none_ff;
      res_found_in  = res_found_ff;
      res_rej_in    = res_rej_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_head_in   = rsp_head_ff;
      rsp_none_in   = rsp_none_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_rej_in    = rsp_rej_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      slot_raddr    = ptr_ff;
      slot_we       = 1'b0;
      slot_waddr    = ptr_ff;
      slot_wdata    = carry_ff;
      wt_wr.en      = 1'b0;
      wt_wr.id      = req_entry_id;
      wt_wr.data    = req_weight_value;

      case (state_ff)
         ST_IDLE: begin
            res_head_in  = '0;
            res_none_in  = 1'b0;
            res_found_in = 1'b0;
            res_rej_in   = 1'b0;
            key_in       = req_entry_id;
            ptr_in       = head_ff;
            if (req_fire) begin
               state_in = ST_POST;
               case (action_type'(req_action))
                  ACT_ENQ: begin
                     if (count_ff >= cap_eff) begin
                        res_rej_in = 1'b1;
                     end else begin
                        slot_we    = 1'b1;
                        slot_waddr = tail_ff;
                        slot_wdata = req_entry_id;
                        count_in   = count_ff + CNT_W'(1);
                        tail_in    = wrap_inc(tail_ff, cap_eff);
                     end
                  end
                  ACT_DEQ: begin
                     if (count_ff == '0) begin
                        res_none_in = 1'b1;
                     end else begin
                        slot_raddr = head_ff;
                        state_in   = ST_DEQ;
                     end
                  end
                  ACT_SORT: begin
                     pass_in  = count_ff;
                     state_in = ST_PASS;
                  end
                  ACT_HAS: begin
                     step_in  = '0;
                     state_in = ST_HAS;
                  end
                  ACT_CLEAR: begin
                     head_in  = tail_ff;
                     count_in = '0;
                  end
                  ACT_SETW: begin
                     wt_wr.en = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end else if (csr_wr && csr_idx == REG_QUEUE_CAPACITY) begin
               cap_in   = csr_pwdata[CAP_W-1:0];
               head_in  = '0;
               tail_in  = '0;
               count_in = '0;
            end
         end

         ST_DEQ: begin
            res_head_in = slot_rd_ff;
            head_in     = wrap_inc(head_ff, cap_eff);
            count_in    = count_ff - CNT_W'(1);
            state_in    = ST_POST;
         end

         ST_HAS: begin
            if (step_ff == count_ff) begin
               state_in = ST_POST;
            end else begin
               slot_raddr = ptr_ff;
               state_in   = ST_HAS_CMP;
            end
         end

         ST_HAS_CMP: begin
            if (slot_rd_ff == key_ff) begin
               res_found_in = 1'b1;
               state_in     = ST_POST;
            end else begin
               ptr_in   = nptr;
               step_in  = step_ff + CNT_W'(1);
               state_in = ST_HAS;
            end
         end

         // one bubble pass carries the lighter element toward the pass end
         ST_PASS: begin
            if (pass_ff < CNT_W'(2)) begin
               state_in = ST_POST;
            end else begin
               slot_raddr = head_ff;
               ptr_in     = head_ff;
               step_in    = CNT_W'(1);
               state_in   = ST_CARRY_W;
            end
         end

         ST_CARRY_W: begin
            carry_in = slot_rd_ff;
            state_in = ST_CARRY_LD;
         end

         ST_CARRY_LD: begin
            carry_w_in = wt_rd;
            slot_raddr = nptr;
            state_in   = ST_NEXT_W;
         end

         ST_NEXT_W: begin
            next_in  = slot_rd_ff;
            state_in = ST_CMP;
         end

         ST_CMP: begin
            slot_we    = 1'b1;
            slot_waddr = ptr_ff;
            if (swap) begin
               slot_wdata = next_ff;
            end else begin
               slot_wdata = carry_ff;
               carry_in   = next_ff;
               carry_w_in = wt_rd;
            end
            ptr_in = nptr;
            if (step_ff == pass_ff - CNT_W'(1)) begin
               state_in = ST_LAST;
            end else begin
               step_in    = step_ff + CNT_W'(1);
               slot_raddr = wrap_inc(nptr, cap_eff);
               state_in   = ST_NEXT_W;
            end
         end

         ST_LAST: begin
            slot_we    = 1'b1;
            slot_waddr = ptr_ff;
            slot_wdata = carry_ff;
            pass_in    = pass_ff - CNT_W'(1);
            state_in   = ST_PASS;
         end

         ST_POST: begin
            // hold until the rsp register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_head_in  = res_head_ff;
               rsp_none_in  = res_none_ff;
               rsp_found_in = res_found_ff;
               rsp_rej_in   = res_rej_ff;
               rsp_occ_in   = CAP_W'(count_ff);
               rsp_empty_in = (count_ff == '0);
               rsp_full_in  = (count_ff == cap_eff);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         ptr_ff       <= '0;
         step_ff      <= '0;
         pass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         step_ff      <= step_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff       <= key_in;
      carry_ff     <= carry_in;
      carry_w_ff   <= carry_w_in;
      next_ff      <= next_in;
      res_head_ff  <= res_head_in;
      res_none_ff  <= res_none_in;
      res_found_ff <= res_found_in;
      res_rej_ff   <= res_rej_in;
      rsp_head_ff  <= rsp_head_in;
      rsp_none_ff  <= rsp_none_in;
      rsp_found_ff <= rsp_found_in;
      rsp_rej_ff   <= rsp_rej_in;
      rsp_occ_ff   <= rsp_occ_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_head_entry    = rsp_head_ff;
   assign rsp_no_entity     = rsp_none_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_rejected_full = rsp_rej_ff;
   assign rsp_occupancy     = rsp_occ_ff;
   assign rsp_is_empty_flag = rsp_empty_ff;
   assign rsp_is_full_flag  = rsp_full_ff;

endmodule

@@ bench/tb_weighted_ring_queue.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the weighted ring queue: directed, capacity, full-queue sort and random traffic.
module tb_weighted_ring_queue
   import wrq_pkg::*;
();

   localparam int QUIET_LIMIT = 30000;
   localparam int DRAIN_PAD   = 16;
   localparam int MAX_GAP     = 40;

   localparam logic [ACT_W-1:0]  ACT_SPARE_6   = 3'd6;
   localparam logic [ACT_W-1:0]  ACT_SPARE_7   = 3'd7;
   localparam logic [CSR_AW-1:0] CAP_ADDR      = CSR_AW'(4 * REG_QUEUE_CAPACITY);
   localparam logic [CSR_AW-1:0] UNMAPPED_ADDR = CSR_AW'(4);

   typedef struct packed {
      logic [ID_W-1:0]  head_entry;
      logic             no_entity;
      logic             found;
      logic             rejected_full;
      logic [CAP_W-1:0] occupancy;
      logic             is_empty_flag;
      logic             is_full_flag;
   } queue_status_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [ACT_W-1:0]       req_action = '0;
   logic [ID_W-1:0]        req_entry_id = '0;
   logic signed [WT_W-1:0] req_weight_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [ID_W-1:0]        rsp_head_entry;
   logic                   rsp_no_entity;
   logic                   rsp_found;
   logic                   rsp_rejected_full;
   logic [CAP_W-1:0]       rsp_occupancy;
   logic                   rsp_is_empty_flag;
   logic                   rsp_is_full_flag;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]      csr_paddr = '0;
   logic [CSR_DW-1:0]      csr_pwdata = '0;
   logic [CSR_DW-1:0]      csr_prdata;
   logic                   csr_pready;

   // Shadow of the queue, the weight table and the capacity register
   logic [ID_W-1:0]        q_slots [MAX_SLOTS];
   logic signed [WT_W-1:0] wt_table [ID_SPACE];
   logic [CAP_W-1:0]       q_cap = CAP_RESET;
   int                     q_head = 0;
   int                     q_tail = 0;
   int                     q_count = 0;

   queue_status_type pending_status[$];
   int               mismatches = 0;
   int               quiet_cycles = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;

   weighted_ring_queue dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_entry_id      (req_entry_id),
      .req_weight_value  (req_weight_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_head_entry    (rsp_head_entry),
      .rsp_no_entity     (rsp_no_entity),
      .rsp_found         (rsp_found),
      .rsp_rejected_full (rsp_rejected_full),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_is_empty_flag (rsp_is_empty_flag),
      .rsp_is_full_flag  (rsp_is_full_flag),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Apply one action to the shadow queue and return the status it should report
   function automatic queue_status_type apply_action(input logic [ACT_W-1:0] act,
                                                     input logic [ID_W-1:0] id,
                                                     input logic signed [WT_W-1:0] wv);
      queue_status_type st;
      int               cap;
      int               a;
      int               b;
      logic [ID_W-1:0]  tmp;
      st = '0;
      cap = (q_cap == 0) ? 1 : ((q_cap > MAX_SLOTS) ? MAX_SLOTS : int'(q_cap));
      case (act)
         ACT_ENQ: begin
            if (q_count >= cap) begin
               st.rejected_full = 1'b1;
            end else begin
               q_slots[q_tail % cap] = id;
               q_count++;
               q_tail = (q_tail + 1) % cap;
            end
         end
         ACT_DEQ: begin
            if (q_count == 0) begin
               st.no_entity = 1'b1;
            end else begin
               st.head_entry = q_slots[q_head % cap];
               q_head = (q_head + 1) % cap;
               q_count--;
            end
         end
         ACT_SORT: begin
            // swap only on strictly smaller weight, so ties keep their order
            for (int i = 0; i < q_count; i++) begin
               for (int j = 0; j + 1 < q_count - i; j++) begin
                  a = (q_head + j) % cap;
                  b = (q_head + j + 1) % cap;
                  if (wt_table[q_slots[a]] < wt_table[q_slots[b]]) begin
                     tmp = q_slots[a];
                     q_slots[a] = q_slots[b];
                     q_slots[b] = tmp;
                  end
               end
            end
         end
         ACT_HAS: begin
            for (int i = 0; i < q_count; i++) begin
               if (q_slots[(q_head + i) % cap] == id) st.found = 1'b1;
            end
         end
         ACT_CLEAR: begin
            q_head = q_tail;
            q_count = 0;
         end
         ACT_SETW: begin
            wt_table[id] = wv;
         end
         default: begin
         end
      endcase
      st.occupancy = CAP_W'(q_count);
      st.is_empty_flag = (q_count == 0);
      st.is_full_flag = (q_count == cap);
      return st;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_results
      queue_status_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result transaction, expected none actual occupancy %0d",
                     $time, rsp_occupancy);
         end else begin
            want = pending_status.pop_front();
            check_field("head_entry", 32'(want.head_entry), 32'(rsp_head_entry));
            check_field("no_entity", 32'(want.no_entity), 32'(rsp_no_entity));
            check_field("found", 32'(want.found), 32'(rsp_found));
            check_field("rejected_full", 32'(want.rejected_full), 32'(rsp_rejected_full));
            check_field("occupancy", 32'(want.occupancy), 32'(rsp_occupancy));
            check_field("is_empty_flag", 32'(want.is_empty_flag), 32'(rsp_is_empty_flag));
            check_field("is_full_flag", 32'(want.is_full_flag), 32'(rsp_is_full_flag));
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding", $time,
                  pending_status.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_action(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id,
                              input logic signed [WT_W-1:0] wv);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct && gap < MAX_GAP) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_entry_id <= id;
      req_weight_value <= wv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_status.push_back(apply_action(act, id, wv));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
   endtask

   task automatic csr_transfer(input logic wr, input logic [CSR_AW-1:0] addr,
                               input logic [CSR_DW-1:0] data,
                               output logic [CSR_DW-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write the capacity while idle, then read it back
   task automatic set_capacity(input logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] rd;
      drain_results();
      csr_transfer(1'b1, CAP_ADDR, value, rd);
      q_cap = value[CAP_W-1:0];
      q_head = 0;
      q_tail = 0;
      q_count = 0;
      // idle between the write and the readback
      @(posedge clock);
      csr_transfer(1'b0, CAP_ADDR, '0, rd);
      check_field("queue_capacity", CSR_DW'(value[CAP_W-1:0]), rd);
   endtask

   function automatic logic signed [WT_W-1:0] pick_weight();
      case ($urandom_range(0, 5))
         0: return -1;
         1: return '0;
         2: return 32'sh7FFF_FFFF;
         3: return 32'sh8000_0000;
         4: return {14'd0, 2'($urandom_range(0, 3)), 16'd0};
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_action();
      int               r;
      logic [ACT_W-1:0] act;
      logic [ID_W-1:0]  id;
      r = $urandom_range(0, 99);
      if (r < 34) act = ACT_ENQ;
      else if (r < 54) act = ACT_DEQ;
      else if (r < 60) act = ACT_SORT;
      else if (r < 72) act = ACT_HAS;
      else if (r < 75) act = ACT_CLEAR;
      else if (r < 94) act = ACT_SETW;
      else if (r < 97) act = ACT_SPARE_6;
      else act = ACT_SPARE_7;
      // a small pool of identifiers makes membership hits and weight ties common
      id = ($urandom_range(0, 1) == 0) ? ID_W'($urandom_range(0, 7)) : ID_W'($urandom);
      send_action(act, id, pick_weight());
   endtask

   task automatic test_directed_ops();
      send_action(ACT_DEQ, 6'd0, '0);
      send_action(ACT_HAS, 6'd0, '0);
      send_action(ACT_ENQ, 6'd0, '0);
      send_action(ACT_ENQ, 6'd63, '0);
      send_action(ACT_ENQ, 6'd21, '0);
      send_action(ACT_SETW, 6'd63, 32'sh7FFF_FFFF);
      send_action(ACT_SETW, 6'd0, 32'sh8000_0000);
      send_action(ACT_SETW, 6'd21, -1);
      send_action(ACT_SORT, 6'd0, '0);
      send_action(ACT_HAS, 6'd63, '0);
      send_action(ACT_HAS, 6'd42, '0);
      send_action(ACT_DEQ, 6'd0, '0);
      send_action(ACT_SPARE_6, 6'd21, '0);
      send_action(ACT_SPARE_7, 6'd63, -1);
      send_action(ACT_CLEAR, 6'd0, '0);
      send_action(ACT_DEQ, 6'd0, '0);
      send_action(ACT_SORT, 6'd0, '0);
   endtask

   task automatic test_capacity_register();
      logic [CSR_DW-1:0] rd;
      set_capacity(32'd1);
      send_action(ACT_ENQ, 6'd5, '0);
      send_action(ACT_ENQ, 6'd6, '0);
      send_action(ACT_HAS, 6'd5, '0);
      // zero acts as one; the write also empties the queue
      set_capacity(32'd0);
      send_action(ACT_DEQ, 6'd0, '0);
      send_action(ACT_ENQ, 6'd7, '0);
      send_action(ACT_ENQ, 6'd8, '0);
      // a write to an unmapped address must leave the queue alone
      drain_results();
      csr_transfer(1'b1, UNMAPPED_ADDR, 32'h0000_0003, rd);
      send_action(ACT_DEQ, 6'd0, '0);
      // upper bits dropped, 127 is clamped to the slot count
      set_capacity(32'hFFFF_FFFF);
      send_action(ACT_ENQ, 6'd9, '0);
      set_capacity(CSR_DW'(MAX_SLOTS));
   endtask

   task automatic test_full_queue_sort();
      set_capacity(CSR_DW'(MAX_SLOTS));
      for (int i = 0; i < ID_SPACE; i++) begin
         send_action(ACT_SETW, ID_W'(i), pick_weight());
      end
      repeat (MAX_SLOTS + 1) send_action(ACT_ENQ, ID_W'($urandom), '0);
      send_action(ACT_SORT, '0, '0);
      send_action(ACT_HAS, ID_W'($urandom), '0);
      repeat (MAX_SLOTS + 1) send_action(ACT_DEQ, '0, '0);
   endtask

   task automatic test_random_traffic(input int cap_lo, input int cap_hi, input int n_items);
      set_capacity(CSR_DW'($urandom_range(cap_lo, cap_hi)));
      repeat (n_items) send_random_action();
   endtask

   initial begin
      for (int i = 0; i < ID_SPACE; i++) wt_table[i] = '0;
      for (int i = 0; i < MAX_SLOTS; i++) q_slots[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 38;
      recv_idle_pct = 69;
      test_directed_ops();
      test_capacity_register();
      test_random_traffic(2, 9, 260);

      send_idle_pct = 69;
      recv_idle_pct = 38;
      test_full_queue_sort();
      test_random_traffic(10, MAX_SLOTS, 260);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(1, MAX_SLOTS, 260);

      drain_results();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ weighted_ring_queue.f @@
hdl/wrq_pkg.sv
hdl/wrq_weight_table.sv
hdl/weighted_ring_queue.sv
bench/tb_weighted_ring_queue.sv
